// ===== hw/rtl/ihs_pkg.sv =====
`timescale 1ns / 1ps

package ihs_pkg;

  // table geometry (bucket count is a power of two, bucket index is the low key bits)
  localparam int BUCKETS    = 1024;
  localparam int WAYS       = 4;
  localparam int KEY_W      = 32;
  localparam int BKT_W      = $clog2(BUCKETS);
  localparam int COUNT_W    = 13;
  localparam int OUT_DATA_W = 16;

  // request codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // one bucket row: valid marks and keys of all ways
  typedef struct packed {
    logic [WAYS-1:0]            vld;
    logic [WAYS-1:0][KEY_W-1:0] keys;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // outcome of one bucket lookup
  typedef struct packed {
    logic hit;
    logic ins;
    logic full;
  } match_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

endpackage

// ===== hw/rtl/ihs_row_ram.sv =====
`timescale 1ns / 1ps

module ihs_row_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/ihs_bucket_match.sv =====
`timescale 1ns / 1ps

module ihs_bucket_match (
  input  ihs_pkg::row_t              row,
  input  logic                       cmd,
  input  logic [ihs_pkg::KEY_W-1:0]  key,
  output ihs_pkg::match_t            res,
  output ihs_pkg::row_t              new_row
);

  logic                     hit;
  logic                     have_free;
  logic [ihs_pkg::WAYS-1:0] free_oh;

  // compare all valid ways and pick the lowest free way
  always_comb begin
    hit       = 1'b0;
    have_free = 1'b0;
    free_oh   = '0;
    for (int w = 0; w < ihs_pkg::WAYS; w++) begin
      if (row.vld[w]) begin
        if (row.keys[w] == key) begin
          hit = 1'b1;
        end
      end else if (!have_free) begin
        have_free  = 1'b1;
        free_oh[w] = 1'b1;
      end
    end
  end

  // decide the outcome and build the row to write back
  always_comb begin
    res.hit  = hit;
    res.ins  = (cmd == ihs_pkg::CMD_INSERT) && !hit && have_free;
    res.full = (cmd == ihs_pkg::CMD_INSERT) && !hit && !have_free;
    new_row  = row;
    for (int w = 0; w < ihs_pkg::WAYS; w++) begin
      if (free_oh[w]) begin
        new_row.vld[w]  = 1'b1;
        new_row.keys[w] = key;
      end
    end
  end

endmodule

// ===== hw/rtl/integer_hash_set.sv =====
`timescale 1ns / 1ps
// channel | direction | tdata                        | tuser
// in_     | input     | key (32, signed)             | cmd (0 insert, 1 search)
// out_    | output    | stored_count (13), zero fill | found, inserted, bucket_full
//
// one item per cycle while no result stalls: the bucket row read is issued at
// accept, compared in the next cycle and written back at once; a register forwards
// the last written row so back-to-back items to one bucket see fresh contents
// after reset a clearing pass writes every bucket row before any item
// a stalled result holds the compare stage, which holds the input

module integer_hash_set (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [12:0] stored_count, [15:13] zero
  output logic [2:0]  out_tuser   // [0] found, [1] inserted, [2] bucket_full
);

  ihs_pkg::state_t state_r, state_nxt;
  logic            clearing;

  logic [ihs_pkg::BKT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                      clr_last;

  logic                        in_acc;
  logic                        s2_vld_r;
  logic                        s2_cmd_r;
  logic [ihs_pkg::KEY_W-1:0]   s2_key_r;
  logic [ihs_pkg::BKT_W-1:0]   s2_bkt_r;
  logic                        s2_go;

  logic                      byp_vld_r;
  logic [ihs_pkg::BKT_W-1:0] byp_bkt_r;
  ihs_pkg::row_t             byp_row_r;

  logic [ihs_pkg::ROW_W-1:0] ram_rdata;
  ihs_pkg::row_t             cur_row;
  ihs_pkg::row_t             new_row;
  ihs_pkg::match_t           res;

  logic                        ram_we;
  logic [ihs_pkg::BKT_W-1:0]   ram_waddr;
  logic [ihs_pkg::ROW_W-1:0]   ram_wdata;
  logic                        run_wr;

  logic [ihs_pkg::COUNT_W-1:0] count_r, count_nxt;

  logic                        out_vld_r;
  logic                        out_found_r;
  logic                        out_ins_r;
  logic                        out_full_r;
  logic [ihs_pkg::COUNT_W-1:0] out_count_r;

  // state register and clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ihs_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  assign clr_last = (clr_cnt_r == ihs_pkg::BKT_W'(ihs_pkg::BUCKETS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ihs_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ihs_pkg::ST_RUN;
        end
      end
      ihs_pkg::ST_RUN: begin
        state_nxt = ihs_pkg::ST_RUN;
      end
      default: begin
        state_nxt = ihs_pkg::ST_CLEAR;
      end
    endcase
  end

  // state outputs
  always_comb begin
    clearing    = 1'b0;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ihs_pkg::ST_CLEAR: begin
        clearing    = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ihs_pkg::ST_RUN: begin
        clearing = 1'b0;
      end
      default: begin
        clearing = 1'b1;
      end
    endcase
  end

  // handshakes
  assign s2_go     = s2_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !clearing && (!s2_vld_r || s2_go);
  assign in_acc    = in_tvalid && in_tready;

  // compare stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (in_acc) begin
      s2_vld_r <= 1'b1;
    end else if (s2_go) begin
      s2_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_cmd_r <= in_tuser;
      s2_key_r <= in_tdata;
      s2_bkt_r <= in_tdata[ihs_pkg::BKT_W-1:0];
    end
  end

  // bucket row memory
  ihs_row_ram #(
    .WIDTH (ihs_pkg::ROW_W),
    .DEPTH (ihs_pkg::BUCKETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_tdata[ihs_pkg::BKT_W-1:0]),
    .rdata (ram_rdata)
  );

  // forward the last written row when it belongs to this bucket
  assign cur_row = (byp_vld_r && (byp_bkt_r == s2_bkt_r)) ? byp_row_r
                                                          : ihs_pkg::row_t'(ram_rdata);

  ihs_bucket_match u_match (
    .row     (cur_row),
    .cmd     (s2_cmd_r),
    .key     (s2_key_r),
    .res     (res),
    .new_row (new_row)
  );

  // write port: clearing pass or insert write-back
  assign run_wr    = s2_go && res.ins;
  assign ram_we    = clearing || run_wr;
  assign ram_waddr = clearing ? clr_cnt_r : s2_bkt_r;
  assign ram_wdata = clearing ? '0 : ihs_pkg::ROW_W'(new_row);

  // forwarding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_vld_r <= 1'b0;
    end else if (run_wr) begin
      byp_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (run_wr) begin
      byp_bkt_r <= s2_bkt_r;
      byp_row_r <= new_row;
    end
  end

  // stored key count
  assign count_nxt = count_r + ihs_pkg::COUNT_W'(res.ins);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (s2_go) begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s2_go) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_found_r <= res.hit;
      out_ins_r   <= res.ins;
      out_full_r  <= res.full;
      out_count_r <= count_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(ihs_pkg::OUT_DATA_W - ihs_pkg::COUNT_W){1'b0}}, out_count_r};
  assign out_tuser  = {out_full_r, out_ins_r, out_found_r};

`ifndef NO_ASSERTIONS
  // no item is taken during the clearing pass
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("item accepted during clearing pass");

  // an insert write-back raises the count by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    run_wr |=> (count_r == $past(count_r) + 1'b1))
    else $error("count did not follow insert");

  // a result never reports both a hit and a store or a drop
  a_outcome_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tuser))
    else $error("conflicting result flags");

  // a held result keeps the compare stage from advancing
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready && s2_vld_r) |=> s2_vld_r && $stable(s2_key_r))
    else $error("compare stage moved under a stalled result");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 5000;   // cycles with no item moving, covers clearing pass
  localparam int HOLD_CYCLES = 200;    // long receiver hold-off
  localparam int DRAIN_TAIL  = 10;
  localparam int RANDOM_ITEMS = 427;

  // expected reply for one request
  typedef struct {
    bit               found;
    bit               inserted;
    bit               bucket_full;
    logic [ihs_pkg::COUNT_W-1:0] count;
  } set_reply_t;

  // tracks table contents and matches replies against predictions
  class key_set_tracker;
    logic [ihs_pkg::KEY_W-1:0]   slot_key [ihs_pkg::BUCKETS][ihs_pkg::WAYS];
    bit                          slot_used[ihs_pkg::BUCKETS][ihs_pkg::WAYS];
    logic [ihs_pkg::COUNT_W-1:0] key_total;
    set_reply_t                  replies_due[$];
    int                          errors;
    int                          replies_seen;

    function void clear_table();
      foreach (slot_used[b, w]) slot_used[b][w] = 0;
      key_total    = '0;
      errors       = 0;
      replies_seen = 0;
    endfunction

    // key modulo bucket count, made non-negative
    function int bucket_index(logic signed [ihs_pkg::KEY_W-1:0] key);
      int r;
      r = int'(key) % ihs_pkg::BUCKETS;
      if (r < 0) r += ihs_pkg::BUCKETS;
      return r;
    endfunction

    function void note_request(logic cmd, logic [ihs_pkg::KEY_W-1:0] key);
      set_reply_t rep;
      int b;
      int free_way;
      b        = bucket_index(key);
      free_way = -1;
      rep      = '{default: 0};
      for (int w = 0; w < ihs_pkg::WAYS; w++) begin
        if (slot_used[b][w]) begin
          if (slot_key[b][w] == key) rep.found = 1;
        end else if (free_way < 0) begin
          free_way = w;
        end
      end
      // only an insert of an absent key touches the table
      if (cmd == ihs_pkg::CMD_INSERT && !rep.found) begin
        if (free_way >= 0) begin
          slot_key[b][free_way]  = key;
          slot_used[b][free_way] = 1;
          key_total++;
          rep.inserted = 1;
        end else begin
          rep.bucket_full = 1;
        end
      end
      rep.count = key_total;
      replies_due.push_back(rep);
    endfunction

    function void mismatch(string field, longint unsigned want, longint unsigned got);
      errors++;
      $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_reply(logic [ihs_pkg::OUT_DATA_W-1:0] data, logic [2:0] user);
      set_reply_t want;
      replies_seen++;
      if (replies_due.size() == 0) begin
        errors++;
        $error("reply with no request waiting: tdata %h tuser %b", data, user);
        return;
      end
      want = replies_due.pop_front();
      if (user[0] !== want.found) mismatch("found", want.found, user[0]);
      if (user[1] !== want.inserted) mismatch("inserted", want.inserted, user[1]);
      if (user[2] !== want.bucket_full) mismatch("bucket_full", want.bucket_full, user[2]);
      if (data[ihs_pkg::COUNT_W-1:0] !== want.count)
        mismatch("stored_count", want.count, data[ihs_pkg::COUNT_W-1:0]);
      if (data[ihs_pkg::OUT_DATA_W-1:ihs_pkg::COUNT_W] !== '0)
        mismatch("tdata zero fill", 0, data[ihs_pkg::OUT_DATA_W-1:ihs_pkg::COUNT_W]);
    endfunction

    function int waiting();
      return replies_due.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [31:0]                    in_tdata;
  logic                           in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [ihs_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [2:0]                     out_tuser;

  key_set_tracker  tracker = new;
  bit              steady;       // no idling on either side while set
  bit              held_once;
  int              quiet_cycles;
  logic [ihs_pkg::KEY_W-1:0] key_pool[$];

  integer_hash_set DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // observe both channels, watch for a stuck block
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.note_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) tracker.check_reply(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("integer_hash_set verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side: random stalls, one long hold-off
  initial begin
    out_tready = 1'b0;
    held_once  = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held_once && tracker.replies_seen >= 300) begin
        held_once = 1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= steady || ($urandom_range(99) >= 36);
    end
  end

  // offer one item and wait until it is taken, then maybe idle
  task automatic send_request(input logic cmd, input logic [ihs_pkg::KEY_W-1:0] key);
    in_tuser  <= cmd;
    in_tdata  <= key;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == ihs_pkg::CMD_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > 64) void'(key_pool.pop_front());
    end
    if (!steady) begin
      while ($urandom_range(99) < 36) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // mostly keys that collide in a few buckets or repeat, some fully random
  task automatic send_random_request();
    logic [ihs_pkg::KEY_W-1:0] key;
    int                        pick;
    int                        hot;
    logic                      cmd;
    pick = $urandom_range(99);
    cmd  = $urandom_range(1) ? ihs_pkg::CMD_SEARCH : ihs_pkg::CMD_INSERT;
    if (pick < 30 && key_pool.size() > 0) begin
      key = key_pool[$urandom_range(key_pool.size() - 1)];
    end else if (pick < 75) begin
      hot = $urandom_range(15);
      if (hot >= 8) hot = ihs_pkg::BUCKETS - 16 + hot;
      key = (int'($urandom_range(15)) - 8) * ihs_pkg::BUCKETS + hot;
    end else begin
      key = $urandom;
    end
    send_request(cmd, key);
  endtask

  // stimulus
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ihs_pkg::CMD_INSERT;
    steady    = 0;
    quiet_cycles = 0;
    tracker.clear_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, repeated key, extreme keys
    send_request(ihs_pkg::CMD_SEARCH, 32'h0000_0000);
    send_request(ihs_pkg::CMD_INSERT, 32'h0000_0000);
    send_request(ihs_pkg::CMD_INSERT, 32'h0000_0000);
    send_request(ihs_pkg::CMD_SEARCH, 32'h0000_0000);
    send_request(ihs_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    send_request(ihs_pkg::CMD_INSERT, 32'h8000_0000);
    send_request(ihs_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_request(ihs_pkg::CMD_SEARCH, 32'h8000_0000);
    send_request(ihs_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
    // fill the lowest bucket, then overflow it
    send_request(ihs_pkg::CMD_INSERT, -32'sd1024);
    send_request(ihs_pkg::CMD_INSERT, 32'd1024);
    send_request(ihs_pkg::CMD_INSERT, 32'd2048);
    send_request(ihs_pkg::CMD_SEARCH, 32'd2048);
    send_request(ihs_pkg::CMD_INSERT, 32'h0000_0000);
    // fill the highest bucket with negative and positive keys
    send_request(ihs_pkg::CMD_INSERT, -32'sd1025);
    send_request(ihs_pkg::CMD_INSERT, 32'h7FFF_FBFF);
    send_request(ihs_pkg::CMD_INSERT, 32'd1023);
    send_request(ihs_pkg::CMD_SEARCH, 32'd1023);
    send_request(ihs_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
    // alternating bit patterns
    send_request(ihs_pkg::CMD_SEARCH, 32'h5555_5555);
    send_request(ihs_pkg::CMD_INSERT, 32'hAAAA_AAAA);
    send_request(ihs_pkg::CMD_INSERT, 32'h5555_5555);
    send_request(ihs_pkg::CMD_SEARCH, 32'hAAAA_AAAA);

    // random part, with a stretch of no idling
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 120 && i < 240);
      send_random_request();
    end
    steady = 0;
    in_tvalid <= 1'b0;

    // drain
    @(posedge clk);
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (tracker.waiting() != 0)
      $error("replies missing: %0d", tracker.waiting());
    if (tracker.errors == 0 && tracker.waiting() == 0) begin
      $display("integer_hash_set verification clean");
    end else begin
      $display("integer_hash_set verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ihs_pkg.sv
hw/rtl/ihs_row_ram.sv
hw/rtl/ihs_bucket_match.sv
hw/rtl/integer_hash_set.sv
tb/testbench.sv
